FILE: hdl/ppts_pkg.sv
// shared types and constants for the perspective projection core
`default_nettype none
package ppts_pkg;

  localparam int COEF_W     = 32;
  localparam int PT_W       = 32;
  localparam int SIZE_W     = 16;
  localparam int TERM_LIM_B = 47;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int SCR_REG_W  = 32;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X_FIRST   = 4'd0,
    REG_ROW_X_SECOND  = 4'd1,
    REG_ROW_Y_FIRST   = 4'd2,
    REG_ROW_Y_SECOND  = 4'd3,
    REG_ROW_W_FIRST   = 4'd4,
    REG_ROW_W_SECOND  = 4'd5,
    REG_SCREEN_SIZE   = 4'd6,
    REG_SCREEN_OFFSET = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] row_x_first;
    logic [CFG_DATA_W-1:0] row_x_second;
    logic [CFG_DATA_W-1:0] row_y_first;
    logic [CFG_DATA_W-1:0] row_y_second;
    logic [CFG_DATA_W-1:0] row_w_first;
    logic [CFG_DATA_W-1:0] row_w_second;
    logic [SCR_REG_W-1:0]  screen_size;
    logic [SCR_REG_W-1:0]  screen_offset;
  } cfg_t;

endpackage
`default_nettype wire

FILE: hdl/ppts_if.sv
// channel interfaces: point input, screen result and register write
`default_nettype none
interface ppts_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;
  modport source (output valid, output world_x, output world_y, output world_z, input ready);
  modport sink   (input valid, input world_x, input world_y, input world_z, output ready);
endinterface

interface ppts_out_if #(parameter int CW = 32);
  logic                valid;
  logic                ready;
  logic signed [CW-1:0] screen_x;
  logic signed [CW-1:0] screen_y;
  logic                visible;
  modport source (output valid, output screen_x, output screen_y, output visible, input ready);
  modport sink   (input valid, input screen_x, input screen_y, input visible, output ready);
endinterface

interface ppts_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/ppts_front.sv
// front end: three matrix rows times the point, summed into x, y and w
`default_nettype none
module ppts_front
  import ppts_pkg::*;
#(
  parameter int F     = 16,
  parameter int DOT_W = 50,
  parameter int ITEM_W = 151
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  ppts_in_if.sink                in_ch,
  input  wire cfg_t              cfg,
  output logic                   o_valid,
  input  wire logic              o_ready,
  output logic [ITEM_W-1:0]      o_data
);

  logic signed [COEF_W-1:0] coef [3][3];
  logic signed [COEF_W-1:0] c3   [3];
  logic signed [PT_W-1:0]   pt   [3];

  logic signed [COEF_W+PT_W-1:0] prod_r [3][3];
  logic signed [COEF_W-1:0]      c3_r   [3];
  logic signed [DOT_W-1:0]       s01_r  [3];
  logic signed [DOT_W-1:0]       s23_r  [3];
  logic signed [DOT_W-1:0]       dot_r  [3];
  logic                          wz2_r, wz3_r;
  logic                          v1_r, v2_r, v3_r;
  logic                          en;

  always_comb begin
    coef[0][0] = cfg.row_x_first[31:0];
    coef[0][1] = cfg.row_x_first[63:32];
    coef[0][2] = cfg.row_x_second[31:0];
    c3[0]      = cfg.row_x_second[63:32];
    coef[1][0] = cfg.row_y_first[31:0];
    coef[1][1] = cfg.row_y_first[63:32];
    coef[1][2] = cfg.row_y_second[31:0];
    c3[1]      = cfg.row_y_second[63:32];
    coef[2][0] = cfg.row_w_first[31:0];
    coef[2][1] = cfg.row_w_first[63:32];
    coef[2][2] = cfg.row_w_second[31:0];
    c3[2]      = cfg.row_w_second[63:32];
    pt[0]      = in_ch.world_x;
    pt[1]      = in_ch.world_y;
    pt[2]      = in_ch.world_z;
  end

  // whole front stalls together when its last stage cannot hand off
  assign en          = !v3_r || o_ready;
  assign in_ch.ready = en;
  assign o_valid     = v3_r;
  assign o_data      = {wz3_r, dot_r[2], dot_r[0], dot_r[1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= coef[r][c] * pt[c];
        end
        c3_r[r]  <= c3[r];
        s01_r[r] <= DOT_W'(prod_r[r][0] >>> F) + DOT_W'(prod_r[r][1] >>> F);
        s23_r[r] <= DOT_W'(prod_r[r][2] >>> F) + DOT_W'(c3_r[r]);
        dot_r[r] <= s01_r[r] + s23_r[r];
      end
      wz2_r <= (c3_r[2] == '0);
      wz3_r <= wz2_r;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ppts_fifo.sv
// small queue between front and back ends
`default_nettype none
module ppts_fifo
  import ppts_pkg::*;
#(
  parameter int W     = 151,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         i_valid,
  output logic              i_ready,
  input  wire logic [W-1:0] i_data,
  output logic              o_valid,
  input  wire logic         o_ready,
  output logic [W-1:0]      o_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  assign i_ready = (count_r != CNT_W'(DEPTH));
  assign o_valid = (count_r != '0);
  assign o_data  = mem[rd_ptr_r];
  assign push    = i_valid && i_ready;
  assign pop     = o_valid && o_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= i_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("queue count above depth");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1) else $error("queue lost a push");

endmodule
`default_nettype wire

FILE: hdl/ppts_back.sv
// back end: pipelined divide by w, pixel mapping and saturation
`default_nettype none
module ppts_back
  import ppts_pkg::*;
#(
  parameter int F      = 16,
  parameter int CW     = 32,
  parameter int DOT_W  = 50,
  parameter int ITEM_W = 151
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              i_valid,
  output logic                   i_ready,
  input  wire logic [ITEM_W-1:0] i_data,
  input  wire cfg_t              cfg,
  ppts_out_if.source             out_ch
);

  localparam int NW    = DOT_W + F;
  localparam int TW    = NW + 2;
  localparam int MTW   = TERM_LIM_B + 2;
  localparam int VW    = SIZE_W + 1 + MTW;
  localparam int W_MIN = (1 << F) / 100;

  localparam logic signed [TW-1:0] ONE_T = {{(TW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [TW-1:0] T_LIM =
    {{(TW-TERM_LIM_B-1){1'b0}}, 1'b1, {TERM_LIM_B{1'b0}}};
  localparam logic signed [VW-1:0] OUT_MAX = {{(VW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [VW-1:0] OUT_MIN = ~OUT_MAX;

  logic                    en, pop;
  logic                    in_wz;
  logic signed [DOT_W-1:0] in_w, in_x, in_y;

  // divider stages
  logic [DOT_W-1:0] rem_r [2][NW+1];
  logic [NW-1:0]    nq_r  [2][NW+1];
  logic [DOT_W-1:0] rem_nxt [2][NW];
  logic [NW-1:0]    nq_nxt  [2][NW];
  logic [DOT_W-1:0] w_r   [NW+1];
  logic [NW:0]      v_r, vis_r, negx_r, negy_r;

  logic [DOT_W:0] trial, diff;
  logic           ge;

  logic signed [TW-1:0]  rx, ry, tx, ty;
  logic signed [MTW-1:0] tx_r, ty_r;
  logic                  pv1_r, pvis1_r;
  logic signed [VW-1:0]  px_r, py_r;
  logic                  pv2_r, pvis2_r;
  logic signed [VW-1:0]  sumx, sumy;
  logic signed [CW-1:0]  sx_r, sy_r;
  logic                  vout_r, vis_out_r;

  assign en      = !vout_r || out_ch.ready;
  assign i_ready = en;
  assign pop     = en && i_valid;

  assign in_wz = i_data[ITEM_W-1];
  assign in_w  = i_data[3*DOT_W-1 -: DOT_W];
  assign in_x  = i_data[2*DOT_W-1 -: DOT_W];
  assign in_y  = i_data[DOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      pv1_r  <= 1'b0;
      pv2_r  <= 1'b0;
      vout_r <= 1'b0;
    end else if (en) begin
      v_r    <= {v_r[NW-1:0], pop};
      pv1_r  <= v_r[NW];
      pv2_r  <= pv1_r;
      vout_r <= pv2_r;
    end
  end

  // one quotient bit per stage, restoring
  always_comb begin
    trial = '0;
    diff  = '0;
    ge    = 1'b0;
    for (int l = 0; l < 2; l++) begin
      for (int s = 0; s < NW; s++) begin
        trial = {rem_r[l][s], nq_r[l][s][NW-1]};
        diff  = trial - {1'b0, w_r[s]};
        ge    = (trial >= {1'b0, w_r[s]});
        rem_nxt[l][s] = ge ? diff[DOT_W-1:0] : trial[DOT_W-1:0];
        nq_nxt[l][s]  = {nq_r[l][s][NW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis_r[0]    <= !in_wz && (in_w >= DOT_W'(W_MIN));
      negx_r[0]   <= in_x[DOT_W-1];
      negy_r[0]   <= in_y[DOT_W-1];
      w_r[0]      <= in_w;
      rem_r[0][0] <= '0;
      rem_r[1][0] <= '0;
      nq_r[0][0]  <= {(in_x[DOT_W-1] ? DOT_W'(-in_x) : in_x), {F{1'b0}}};
      nq_r[1][0]  <= {(in_y[DOT_W-1] ? DOT_W'(-in_y) : in_y), {F{1'b0}}};
      for (int s = 0; s < NW; s++) begin
        w_r[s+1]    <= w_r[s];
        vis_r[s+1]  <= vis_r[s];
        negx_r[s+1] <= negx_r[s];
        negy_r[s+1] <= negy_r[s];
        for (int l = 0; l < 2; l++) begin
          rem_r[l][s+1] <= rem_nxt[l][s];
          nq_r[l][s+1]  <= nq_nxt[l][s];
        end
      end
    end
  end

  // 1 +/- ratio, clamped
  always_comb begin
    rx = negx_r[NW] ? -$signed({2'b00, nq_r[0][NW]}) : $signed({2'b00, nq_r[0][NW]});
    ry = negy_r[NW] ? -$signed({2'b00, nq_r[1][NW]}) : $signed({2'b00, nq_r[1][NW]});
    tx = ONE_T + rx;
    ty = ONE_T - ry;
    if (tx > T_LIM) tx = T_LIM;
    if (tx < -T_LIM) tx = -T_LIM;
    if (ty > T_LIM) ty = T_LIM;
    if (ty < -T_LIM) ty = -T_LIM;
  end

  always_comb begin
    sumx = (px_r >>> 1) + (VW'($signed(cfg.screen_offset[15:0])) <<< F);
    sumy = (py_r >>> 1) + (VW'($signed(cfg.screen_offset[31:16])) <<< F);
    if (sumx > OUT_MAX) sumx = OUT_MAX;
    if (sumx < OUT_MIN) sumx = OUT_MIN;
    if (sumy > OUT_MAX) sumy = OUT_MAX;
    if (sumy < OUT_MIN) sumy = OUT_MIN;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r      <= tx[MTW-1:0];
      ty_r      <= ty[MTW-1:0];
      pvis1_r   <= vis_r[NW];
      px_r      <= $signed({1'b0, cfg.screen_size[15:0]}) * tx_r;
      py_r      <= $signed({1'b0, cfg.screen_size[31:16]}) * ty_r;
      pvis2_r   <= pvis1_r;
      sx_r      <= pvis2_r ? sumx[CW-1:0] : '0;
      sy_r      <= pvis2_r ? sumy[CW-1:0] : '0;
      vis_out_r <= pvis2_r;
    end
  end

  assign out_ch.valid    = vout_r;
  assign out_ch.screen_x = sx_r;
  assign out_ch.screen_y = sy_r;
  assign out_ch.visible  = vis_out_r;

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vout_r && !vis_out_r) |-> (sx_r == '0 && sy_r == '0))
    else $error("hidden point with nonzero position");

endmodule
`default_nettype wire

FILE: hdl/perspective_project_to_screen_core.sv
// top level: register file, front end, queue and back end
//
//  channel  | dir | handshake    | payload
//  in_ch    | in  | valid/ready  | world_x, world_y, world_z
//  out_ch   | out | valid/ready  | screen_x, screen_y, visible
//  cfg_ch   | in  | valid/ready  | index, data (always ready)
//
// one point per cycle sustained while out_ch is ready; points pass the front end,
// queue, back end (66 divider stages, one quotient bit each, then 3 mapping stages)
// rst_n is synchronous; it clears the config registers, valid bits and the queue
// a stalled output freezes the back end; the queue then fills before in_ch.ready drops
`default_nettype none
module perspective_project_to_screen_core
  import ppts_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ppts_in_if.sink   in_ch,
  ppts_out_if.source out_ch,
  ppts_cfg_if.sink  cfg_ch
);

  localparam int DOT_W  = 66 - FRAC_BITS;
  localparam int ITEM_W = 1 + 3 * DOT_W;

  cfg_t              cfg_r;
  logic              f_valid, f_ready, q_valid, q_ready;
  logic [ITEM_W-1:0] f_data, q_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ROW_X_FIRST:   cfg_r.row_x_first   <= cfg_ch.data;
        REG_ROW_X_SECOND:  cfg_r.row_x_second  <= cfg_ch.data;
        REG_ROW_Y_FIRST:   cfg_r.row_y_first   <= cfg_ch.data;
        REG_ROW_Y_SECOND:  cfg_r.row_y_second  <= cfg_ch.data;
        REG_ROW_W_FIRST:   cfg_r.row_w_first   <= cfg_ch.data;
        REG_ROW_W_SECOND:  cfg_r.row_w_second  <= cfg_ch.data;
        REG_SCREEN_SIZE:   cfg_r.screen_size   <= cfg_ch.data[SCR_REG_W-1:0];
        REG_SCREEN_OFFSET: cfg_r.screen_offset <= cfg_ch.data[SCR_REG_W-1:0];
        default: ;
      endcase
    end
  end

  ppts_front #(.F(FRAC_BITS), .DOT_W(DOT_W), .ITEM_W(ITEM_W)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .o_valid (f_valid),
    .o_ready (f_ready),
    .o_data  (f_data)
  );

  ppts_fifo #(.W(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (f_valid),
    .i_ready (f_ready),
    .i_data  (f_data),
    .o_valid (q_valid),
    .o_ready (q_ready),
    .o_data  (q_data)
  );

  ppts_back #(.F(FRAC_BITS), .CW(COORD_WIDTH), .DOT_W(DOT_W), .ITEM_W(ITEM_W)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (q_valid),
    .i_ready (q_ready),
    .i_data  (q_data),
    .cfg     (cfg_r),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire
